[design/first_fit_heap_allocator_assert.svh]
// assertion macros used by the heap allocator sequencer
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffha: implication check failed");

// next-cycle implication, checked outside reset
`define FFHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffha: next-cycle check failed");

`endif

[design/ffha_pkg.sv]
// shared types and constants of the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;

    localparam int OP_W     = 2;
    localparam int SIZE_W   = 12;
    localparam int OFF_W    = 12;
    localparam int HWORDS_W = 11;
    localparam int WORD_W   = 32;
    localparam int NEED_W   = 13;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;

    localparam logic [HWORDS_W-1:0] HEAP_WORDS_RST = 11'd1024;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] size_bytes;
        logic [OFF_W-1:0]  block_offset;
    } t_req;

    typedef struct packed {
        logic [OFF_W-1:0] result_offset;
        logic             ok;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FMT,
        S_DONE,
        A_RD,
        A_EVAL,
        A_FIT,
        A_SPLIT,
        F_RD,
        F_HDR,
        F_NX,
        F_WR
    } t_state;

endpackage

[design/first_fit_heap_allocator.sv]
// top level of the first-fit heap allocator
//
//  channel   direction  handshake                    word
//  in        input      i_in_valid / o_in_ready      i_op, i_size_bytes, i_block_offset
//  out       output     o_out_valid / i_out_ready    o_result_offset, o_ok
//  cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_heap_words
//
// a format writes one header; rejected words (unknown op, bad free, heap under 2 words)
// are answered without a heap access; a free reads the freed header and the headers after
// it, then writes one; an allocate reads headers, tests free blocks for fit and may split;
// the single-port heap ram, one header access per cycle, sets the pace
// reset clears control only; the heap holds garbage until the first format
// a full output register holds the sequencer; the next word is taken in the cycle after hand-over
`timescale 1ns / 1ps
module first_fit_heap_allocator import ffha_pkg::*; #(
    parameter int HEAP_WORDS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic [OFF_W-1:0]    i_block_offset,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OFF_W-1:0]    o_result_offset,
    output logic                o_ok,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [HWORDS_W-1:0] i_cfg_heap_words
);
    localparam int AW = $clog2(HEAP_WORDS);

    // configuration: heap size in words
    logic [HWORDS_W-1:0] r_heap_words;
    logic [HWORDS_W-1:0] act_hw;

    // output register
    logic              r_out_valid;
    logic [OFF_W-1:0]  r_out_offset;
    logic              r_out_ok;

    t_req              req;
    t_rsp              rsp;
    logic              rsp_valid, rsp_ready;
    logic              mem_re, mem_we;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_words <= HEAP_WORDS_RST;
        end else if (i_cfg_valid) begin
            r_heap_words <= i_cfg_heap_words;
        end
    end

    // active size is the configured size limited to the ram depth
    always_comb begin
        if (WORD_W'(r_heap_words) > WORD_W'(HEAP_WORDS)) begin
            act_hw = HWORDS_W'(HEAP_WORDS);
        end else begin
            act_hw = r_heap_words;
        end
    end

    assign req.op           = i_op;
    assign req.size_bytes   = i_size_bytes;
    assign req.block_offset = i_block_offset;

    // the sequencer may hand over a result whenever the output register is empty or frees this cycle
    assign rsp_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rsp_valid && rsp_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_valid && rsp_ready) begin
            r_out_offset <= rsp.result_offset;
            r_out_ok     <= rsp.ok;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_offset = r_out_offset;
    assign o_ok            = r_out_ok;

    ffha_ctrl #(
        .AW (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hw        (act_hw),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .o_mem_re    (mem_re),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    // heap store, one header or payload word per entry
    ffha_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );
endmodule

[design/ffha_ram.sv]
// generic single-port ram with registered read
`timescale 1ns / 1ps
module ffha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/ffha_ctrl.sv]
// request sequencer: walks block headers through the heap ram
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"
module ffha_ctrl import ffha_pkg::*; #(
    parameter int AW = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [HWORDS_W-1:0] i_hw,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  t_req                i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output t_rsp                o_rsp,
    output logic                o_mem_re,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_addr,
    output logic [WORD_W-1:0]   o_mem_wdata,
    input  logic [WORD_W-1:0]   i_mem_rdata
);
    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [NEED_W-1:0]   r_need, n_need;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [HWORDS_W-1:0] r_hw, n_hw;
    logic [AW-1:0]       r_h, n_h;
    logic [AW-1:0]       r_cur, n_cur;
    logic                r_chain, n_chain;
    logic [WORD_W-1:0]   r_hdr, n_hdr;
    logic [OFF_W-1:0]    r_res, n_res;
    logic                r_ok, n_ok;

    logic [WORD_W-1:0] hw32, rd_sz, rd_end, h_end, sz, need32, rem;
    logic [WORD_W-1:0] split_addr, merge_sum, h1, fh, fmt_sz;
    logic              rd_occ, free_ok, mergeable;
    logic [OFF_W-1:0]  res_h;

    always_comb begin
        hw32       = WORD_W'(r_hw);
        rd_sz      = {i_mem_rdata[WORD_W-1:2], 2'b00};
        rd_occ     = i_mem_rdata[0];
        rd_end     = WORD_W'(r_cur) + 32'd1 + {2'b00, i_mem_rdata[WORD_W-1:2]};
        sz         = {r_hdr[WORD_W-1:2], 2'b00};
        h_end      = WORD_W'(r_h) + 32'd1 + {2'b00, r_hdr[WORD_W-1:2]};
        need32     = WORD_W'(r_need);
        rem        = sz - need32;
        split_addr = WORD_W'(r_h) + 32'd1 + WORD_W'(r_need[NEED_W-1:2]);
        merge_sum  = sz + rd_sz + 32'd4;
        h1         = WORD_W'(r_h) + 32'd1;
        res_h      = {h1[OFF_W-3:0], 2'b00};
        fmt_sz     = hw32 - 32'd1;
        mergeable  = !rd_occ && (rd_end <= hw32);
        // header index named by a free request
        fh         = WORD_W'(i_req.block_offset[OFF_W-1:2]) - 32'd1;
        free_ok    = (i_hw >= 11'd2) && (i_req.block_offset[1:0] == 2'b00)
                     && (i_req.block_offset[OFF_W-1:2] != 10'd0)
                     && (fh < WORD_W'(i_hw));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_need  <= n_need;
        r_off   <= n_off;
        r_hw    <= n_hw;
        r_h     <= n_h;
        r_cur   <= n_cur;
        r_chain <= n_chain;
        r_hdr   <= n_hdr;
        r_res   <= n_res;
        r_ok    <= n_ok;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_need      = r_need;
        n_off       = r_off;
        n_hw        = r_hw;
        n_h         = r_h;
        n_cur       = r_cur;
        n_chain     = r_chain;
        n_hdr       = r_hdr;
        n_res       = r_res;
        n_ok        = r_ok;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_h;
        o_mem_wdata = r_hdr;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_op    = i_req.op;
                    n_need  = ({1'b0, i_req.size_bytes} + 13'd3) & 13'h1FFC;
                    n_off   = i_req.block_offset;
                    n_hw    = i_hw;
                    n_h     = '0;
                    n_cur   = '0;
                    n_res   = '0;
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                    unique case (i_req.op)
                        OP_ALLOC: begin
                            if (i_hw >= 11'd2) begin
                                n_state = A_RD;
                            end
                        end
                        OP_FREE: begin
                            n_res = i_req.block_offset;
                            if (free_ok) begin
                                n_h     = fh[AW-1:0];
                                n_state = F_RD;
                            end
                        end
                        OP_FORMAT: begin
                            if (i_hw >= 11'd2) begin
                                n_state = S_FMT;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_FMT: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = '0;
                o_mem_wdata = {fmt_sz[WORD_W-3:0], 2'b00};
                n_res       = 12'd4;
                n_ok        = 1'b1;
                n_state     = S_DONE;
            end
            A_RD: begin
                o_mem_re   = 1'b1;
                o_mem_addr = r_cur;
                n_chain    = 1'b0;
                n_state    = A_EVAL;
            end
            A_EVAL: begin
                if (r_chain && mergeable) begin
                    // absorb the free neighbor into the current block
                    n_hdr       = {merge_sum[WORD_W-1:2], 2'b00};
                    o_mem_we    = 1'b1;
                    o_mem_addr  = r_h;
                    o_mem_wdata = {merge_sum[WORD_W-1:2], 2'b00};
                    n_state     = A_FIT;
                end else begin
                    n_h = r_cur;
                    if (rd_end > hw32) begin
                        n_state = S_DONE;
                    end else if (rd_occ) begin
                        if (rd_end < hw32) begin
                            o_mem_re   = 1'b1;
                            o_mem_addr = rd_end[AW-1:0];
                            n_cur      = rd_end[AW-1:0];
                            n_chain    = 1'b0;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_hdr   = i_mem_rdata;
                        n_state = A_FIT;
                    end
                end
            end
            A_FIT: begin
                if (sz >= need32) begin
                    o_mem_we = 1'b1;
                    if (rem >= 32'd4) begin
                        o_mem_addr  = split_addr[AW-1:0];
                        o_mem_wdata = rem - 32'd4;
                        n_state     = A_SPLIT;
                    end else begin
                        o_mem_addr  = r_h;
                        o_mem_wdata = sz | 32'd1;
                        n_res       = res_h;
                        n_ok        = 1'b1;
                        n_state     = S_DONE;
                    end
                end else if (h_end < hw32) begin
                    o_mem_re   = 1'b1;
                    o_mem_addr = h_end[AW-1:0];
                    n_cur      = h_end[AW-1:0];
                    n_chain    = 1'b1;
                    n_state    = A_EVAL;
                end else begin
                    n_state = S_DONE;
                end
            end
            A_SPLIT: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = r_h;
                o_mem_wdata = need32 | 32'd1;
                n_res       = res_h;
                n_ok        = 1'b1;
                n_state     = S_DONE;
            end
            F_RD: begin
                o_mem_re   = 1'b1;
                o_mem_addr = r_h;
                n_cur      = r_h;
                n_state    = F_HDR;
            end
            F_HDR: begin
                n_hdr = {i_mem_rdata[WORD_W-1:1], 1'b0};
                if (rd_end < hw32) begin
                    o_mem_re   = 1'b1;
                    o_mem_addr = rd_end[AW-1:0];
                    n_cur      = rd_end[AW-1:0];
                    n_state    = F_NX;
                end else begin
                    n_state = F_WR;
                end
            end
            F_NX: begin
                if (mergeable) begin
                    // merged block ends where the absorbed one ended
                    n_hdr = {merge_sum[WORD_W-1:2], 2'b00};
                    if (rd_end < hw32) begin
                        o_mem_re   = 1'b1;
                        o_mem_addr = rd_end[AW-1:0];
                        n_cur      = rd_end[AW-1:0];
                    end else begin
                        n_state = F_WR;
                    end
                end else begin
                    n_state = F_WR;
                end
            end
            F_WR: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = r_h;
                o_mem_wdata = r_hdr;
                n_res       = r_off;
                n_ok        = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    assign o_rsp.result_offset = r_res;
    assign o_rsp.ok            = r_ok;

    `FFHA_ASSERT_IMP(a_mem_in_heap, i_clk, i_rst_n, (o_mem_re || o_mem_we) && r_state != S_IDLE, WORD_W'(o_mem_addr) < WORD_W'(r_hw))
    `FFHA_ASSERT_IMP(a_alloc_in_heap, i_clk, i_rst_n, r_state == S_DONE && r_op == OP_ALLOC && r_ok, WORD_W'(r_h) < WORD_W'(r_hw))
    `FFHA_ASSERT_IMP(a_format_offset, i_clk, i_rst_n, r_state == S_DONE && r_op == OP_FORMAT && r_ok, r_res == 12'd4)
    `FFHA_ASSERT_NXT(a_split_then_hdr, i_clk, i_rst_n, r_state == A_SPLIT, r_state == S_DONE && r_ok)
endmodule

[tb/first_fit_heap_allocator_tb.sv]
// self-checking testbench for the first-fit heap allocator: directed and random requests
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int              HEAP_DEPTH   = 1024;
    localparam logic [OP_W-1:0] OP_UNKNOWN   = 2'd3;
    localparam longint          CYCLE_LIMIT  = 20_000_000;
    localparam int              DRAIN_CYCLES = 8;
    localparam int              PHASE_WORDS  = 272;
    localparam int              PRINT_CAP    = 50;

    // ports of the block
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_op = OP_ALLOC;
    logic [SIZE_W-1:0]   i_size_bytes = '0;
    logic [OFF_W-1:0]    i_block_offset = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [OFF_W-1:0]    o_result_offset;
    logic                o_ok;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [HWORDS_W-1:0] i_cfg_heap_words = HEAP_WORDS_RST;

    // shadow heap: what the block's ram must hold after every accepted word
    logic [WORD_W-1:0]   heap_mem [HEAP_DEPTH];
    bit                  heap_touched [HEAP_DEPTH];
    logic [HWORDS_W-1:0] heap_words_reg = HEAP_WORDS_RST;

    t_rsp   pending_answers [$];
    t_rsp   oldest_answer;

    int     send_idle_pct = 35;
    int     recv_stall_pct = 74;
    int     mismatch_count = 0;
    int     results_checked = 0;
    int     words_accepted = 0;
    int     allocs_granted = 0;
    int     allocs_refused = 0;
    int     frees_taken = 0;
    int     cfg_writes = 0;
    longint cycle_count = 0;

    first_fit_heap_allocator #(
        .HEAP_WORDS(HEAP_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_size_bytes    (i_size_bytes),
        .i_block_offset  (i_block_offset),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_offset (o_result_offset),
        .o_ok            (o_ok),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_heap_words(i_cfg_heap_words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // heap bookkeeping
    // ---------------------------------------------------------------

    // active size: the register, capped at the ram depth
    function automatic longint unsigned active_words();
        return (heap_words_reg > HEAP_DEPTH) ? HEAP_DEPTH : heap_words_reg;
    endfunction

    function automatic longint unsigned block_bytes(input longint unsigned h);
        return longint'(heap_mem[h][WORD_W-1:2]) * 4;
    endfunction

    // header index right after block h, may lie past the heap
    function automatic longint unsigned block_end(input longint unsigned h);
        return h + 1 + longint'(heap_mem[h][WORD_W-1:2]);
    endfunction

    function automatic void heap_write(input longint unsigned idx, input longint unsigned value);
        heap_mem[idx] = value[WORD_W-1:0];
        heap_touched[idx] = 1'b1;
    endfunction

    // payload byte offset of a header, cut to the port width
    function automatic logic [OFF_W-1:0] payload_offset(input longint unsigned hdr);
        longint unsigned bytes;
        bytes = (hdr + 1) * 4;
        return bytes[OFF_W-1:0];
    endfunction

    // fold the free blocks that follow h in a row, each lying wholly inside the heap
    function automatic void merge_after(input longint unsigned h, input longint unsigned hw);
        longint unsigned nx, grown;
        nx = block_end(h);
        while (nx < hw && heap_mem[nx][0] == 1'b0 && block_end(nx) <= hw) begin
            grown = block_bytes(h) + block_bytes(nx) + 4;
            heap_write(h, (grown & ~64'd3) | heap_mem[h][0]);
            nx = block_end(h);
        end
    endfunction

    // first-fit walk from word 0; short free blocks swallow their free
    // neighbors before the walk moves on, and those merges stay on failure
    function automatic bit heap_allocate(input logic [SIZE_W-1:0] size,
                                         input longint unsigned hw,
                                         output longint unsigned hdr);
        longint unsigned need, h, sz, nx;
        need = ((longint'(size) + 3) / 4) * 4;
        h = 0;
        hdr = 0;
        while (h < hw) begin
            // a block running past the heap ends the walk
            if (block_end(h) > hw) return 1'b0;
            if (heap_mem[h][0]) begin
                h = block_end(h);
                continue;
            end
            forever begin
                sz = block_bytes(h);
                nx = block_end(h);
                if (sz >= need) begin
                    // split only if the rest still holds a header
                    if (sz - need >= 4) begin
                        heap_write(h + 1 + need / 4, sz - need - 4);
                        heap_write(h, need | 1);
                    end else begin
                        heap_write(h, sz | 1);
                    end
                    hdr = h;
                    return 1'b1;
                end
                if (nx < hw && heap_mem[nx][0] == 1'b0 && block_end(nx) <= hw) begin
                    heap_write(h, (sz + block_bytes(nx) + 4) & ~64'd3);
                end else begin
                    h = nx;
                    break;
                end
            end
        end
        return 1'b0;
    endfunction

    // expected answer of one request word, heap updated on the way
    function automatic t_rsp apply_heap_request(input t_req rq);
        longint unsigned hw, h;
        t_rsp answer;
        hw = active_words();
        answer.result_offset = '0;
        answer.ok = 1'b0;
        case (rq.op)
            OP_ALLOC: begin
                if (hw >= 2) begin
                    if (heap_allocate(rq.size_bytes, hw, h)) begin
                        answer.result_offset = payload_offset(h);
                        answer.ok = 1'b1;
                    end
                end
                if (answer.ok) allocs_granted++;
                else allocs_refused++;
            end
            OP_FREE: begin
                // offset echoed even when the free is refused
                answer.result_offset = rq.block_offset;
                if (hw >= 2 && rq.block_offset[1:0] == 2'b00 && rq.block_offset >= 4) begin
                    h = longint'(rq.block_offset[OFF_W-1:2]) - 1;
                    if (h < hw) begin
                        heap_write(h, {heap_mem[h][WORD_W-1:1], 1'b0});
                        merge_after(h, hw);
                        answer.ok = 1'b1;
                        frees_taken++;
                    end
                end
            end
            OP_FORMAT: begin
                if (hw >= 2) begin
                    heap_write(0, (hw - 1) * 4);
                    answer.result_offset = 12'd4;
                    answer.ok = 1'b1;
                end
            end
            default: ;
        endcase
        return answer;
    endfunction

    // random header on the chain with the given occupied mark
    function automatic bit pick_block(input bit occupied, output longint unsigned hdr);
        longint unsigned h, hw;
        longint unsigned found [$];
        hw = active_words();
        h = 0;
        hdr = 0;
        while (h < hw) begin
            if (heap_mem[h][0] == occupied) found.push_back(h);
            h = block_end(h);
        end
        if (found.size() == 0) return 1'b0;
        hdr = found[$urandom_range(found.size() - 1)];
        return 1'b1;
    endfunction

    // a free aimed at any word is fine only if every word it reads was written
    function automatic bit free_is_safe(input longint unsigned h, input longint unsigned hw);
        longint unsigned words, nx;
        if (!heap_touched[h]) return 1'b0;
        words = longint'(heap_mem[h][WORD_W-1:2]);
        nx = h + 1 + words;
        while (nx < hw) begin
            if (!heap_touched[nx]) return 1'b0;
            if (heap_mem[nx][0] || block_end(nx) > hw) break;
            words = words + longint'(heap_mem[nx][WORD_W-1:2]) + 1;
            nx = h + 1 + words;
        end
        return 1'b1;
    endfunction

    // offset that the block must turn down: zero, misaligned or past the heap
    function automatic logic [OFF_W-1:0] rejected_offset(input longint unsigned hw);
        int kind;
        kind = $urandom_range(2);
        if (kind == 0) return '0;
        if (kind == 1 || hw > 1022) return {10'($urandom()), 2'($urandom_range(3, 1))};
        return payload_offset($urandom_range(32'd1022, 32'(hw)));
    endfunction

    function automatic logic [SIZE_W-1:0] random_alloc_size(input longint unsigned hw);
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) return SIZE_W'($urandom_range(16));
        if (pick < 80) return SIZE_W'($urandom_range(32'(hw)));
        if (pick < 95) return SIZE_W'($urandom_range((hw * 4 > 4095) ? 32'd4095 : 32'(hw * 4)));
        return SIZE_W'($urandom_range(4095));
    endfunction

    // ---------------------------------------------------------------
    // drivers, entered and left at a falling edge
    // ---------------------------------------------------------------

    // one request word; valid stays up after acceptance unless a gap follows
    task automatic send_request(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
                                input logic [OFF_W-1:0] offset);
        t_req req_word;
        req_word = '{op: op, size_bytes: size, block_offset: offset};
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_size_bytes   <= size;
        i_block_offset <= offset;
        do @(posedge i_clk); while (!o_in_ready);
        pending_answers.push_back(apply_heap_request(req_word));
        words_accepted++;
        @(negedge i_clk);
    endtask

    // block idle: every answer back, then a short settle
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_heap_words(input logic [HWORDS_W-1:0] words);
        wait_for_drain();
        i_cfg_valid      <= 1'b1;
        i_cfg_heap_words <= words;
        do @(posedge i_clk); while (!o_cfg_ready);
        heap_words_reg = words;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: ready changes on the falling edge only
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // answer checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] answer %0d: %s is %0d, expected %0d",
                     $realtime, results_checked, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (pending_answers.size() == 0) begin
                report_mismatch("answer with no request pending, result_offset",
                                32'(o_result_offset), 32'd0);
            end else begin
                oldest_answer = pending_answers.pop_front();
                if (o_result_offset !== oldest_answer.result_offset)
                    report_mismatch("result_offset", 32'(o_result_offset),
                                    32'(oldest_answer.result_offset));
                if (o_ok !== oldest_answer.ok)
                    report_mismatch("ok", 32'(o_ok), 32'(oldest_answer.ok));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("first_fit_heap_allocator_tb: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset-size heap: format, zero and odd sizes, an oversize request, bad
    // and double frees, frees that merge forward
    task automatic test_basic_alloc_free();
        send_request(OP_FORMAT, '0, '0);
        send_request(OP_ALLOC, 12'd0, 12'hFFF);      // empty payload, header at word 0
        send_request(OP_ALLOC, 12'd1, 12'h000);      // rounds to 4 bytes
        send_request(OP_ALLOC, 12'hFFF, 12'h000);    // rounds to 4096, never fits
        send_request(OP_UNKNOWN, 12'hFFF, 12'hFFF);
        send_request(OP_FREE, 12'hFFF, 12'd6);       // misaligned
        send_request(OP_FREE, 12'h000, 12'd0);       // offset zero
        send_request(OP_FREE, 12'h000, 12'd8);       // merges with the tail
        send_request(OP_FREE, 12'h000, 12'd8);       // already free
        send_request(OP_FREE, 12'h000, 12'd4);       // folds everything back
    endtask

    // heap sizes at the bottom of the range, no-split and split of a tiny heap
    task automatic test_heap_size_extremes();
        write_heap_words(11'd0);
        send_request(OP_ALLOC, 12'd4, '0);
        send_request(OP_FREE, '0, 12'd4);
        send_request(OP_FORMAT, '0, '0);
        write_heap_words(11'd1);
        send_request(OP_FORMAT, '0, '0);
        write_heap_words(11'd2);
        send_request(OP_FORMAT, '0, '0);
        send_request(OP_ALLOC, 12'd4, '0);           // exact fit, no room to split
        send_request(OP_FREE, '0, 12'd4);
        send_request(OP_ALLOC, 12'd0, '0);           // split leaves a bare header
        send_request(OP_ALLOC, 12'd0, '0);           // takes the bare header
        send_request(OP_ALLOC, 12'd0, '0);           // heap full
        send_request(OP_FREE, '0, 12'd12);           // header past the heap
        send_request(OP_FREE, '0, 12'd8);
        send_request(OP_FREE, '0, 12'd4);
    endtask

    // oversize register, a block reaching past a shrunk heap, and a payload
    // offset of 4096 that wraps to zero on the port
    task automatic test_malformed_and_wrap();
        write_heap_words(11'd2047);
        send_request(OP_FORMAT, '0, '0);
        write_heap_words(11'd3);                     // shrink without format
        send_request(OP_ALLOC, 12'd0, '0);
        send_request(OP_FREE, '0, 12'd4);
        write_heap_words(11'd1024);
        send_request(OP_FORMAT, '0, '0);
        send_request(OP_ALLOC, 12'd4080, '0);
        send_request(OP_ALLOC, 12'd4, '0);
        send_request(OP_ALLOC, 12'd0, '0);           // lands on the last word
    endtask

    // one random request on the current heap
    task automatic send_random_request();
        longint unsigned hw, hdr, w;
        int roll;
        bit found;
        hw = active_words();
        roll = $urandom_range(99);
        if (hw < 2) begin
            // everything bounces off a heap this small
            send_request(OP_W'($urandom_range(3)), SIZE_W'($urandom()), OFF_W'($urandom()));
        end else if (roll < 50) begin
            send_request(OP_ALLOC, random_alloc_size(hw), OFF_W'($urandom()));
        end else if (roll < 78) begin
            if (pick_block(1'b1, hdr))
                send_request(OP_FREE, SIZE_W'($urandom()), payload_offset(hdr));
            else send_request(OP_ALLOC, random_alloc_size(hw), OFF_W'($urandom()));
        end else if (roll < 84) begin
            // double free of a block that is already free, else a free of a live one
            if (pick_block(1'b0, hdr) || pick_block(1'b1, hdr))
                send_request(OP_FREE, SIZE_W'($urandom()), payload_offset(hdr));
            else send_request(OP_ALLOC, random_alloc_size(hw), OFF_W'($urandom()));
        end else if (roll < 90) begin
            send_request(OP_FREE, SIZE_W'($urandom()), rejected_offset(hw));
        end else if (roll < 93) begin
            // free aimed at a random word, possibly a stale header inside some payload
            found = 1'b0;
            w = 0;
            repeat (8) if (!found) begin
                w = $urandom_range(32'(hw - 1));
                found = free_is_safe(w, hw);
            end
            if (found) begin
                send_request(OP_FREE, SIZE_W'($urandom()), payload_offset(w));
            end else begin
                send_request(OP_FREE, SIZE_W'($urandom()), rejected_offset(hw));
            end
        end else if (roll < 96) begin
            send_request(OP_UNKNOWN, SIZE_W'($urandom()), OFF_W'($urandom()));
        end else begin
            send_request(OP_FORMAT, SIZE_W'($urandom()), OFF_W'($urandom()));
        end
    endtask

    // bursts of requests, each on a freshly sized heap, formatted unless under two words; small
    // heaps dominate so that walks stay short
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int items);
        int start_words, ops, shrink_at, k, pick;
        logic [HWORDS_W-1:0] words;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        start_words = words_accepted;
        while (words_accepted - start_words < items) begin
            pick = $urandom_range(99);
            if (pick < 4) words = HWORDS_W'($urandom_range(1));
            else if (pick < 60) words = HWORDS_W'($urandom_range(24, 2));
            else if (pick < 85) words = HWORDS_W'($urandom_range(160, 25));
            else if (pick < 95) words = HWORDS_W'($urandom_range(1024, 161));
            else words = HWORDS_W'($urandom_range(2047, 1025));
            write_heap_words(words);
            if (active_words() >= 2) begin
                send_request(OP_FORMAT, SIZE_W'($urandom()), OFF_W'($urandom()));
                ops = $urandom_range(60, 20);
            end else begin
                ops = 4;
            end
            // now and then the heap shrinks under live blocks
            shrink_at = ($urandom_range(7) == 0) ? int'($urandom_range(ops - 1, 1)) : -1;
            for (k = 0; k < ops && words_accepted - start_words < items; k++) begin
                if (k == shrink_at && active_words() > 2)
                    write_heap_words(HWORDS_W'($urandom_range(32'(active_words() - 1), 2)));
                send_random_request();
            end
        end
        wait_for_drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_alloc_free();
        test_heap_size_extremes();
        test_malformed_and_wrap();
        // sender gaps with a slow receiver, then the reverse, then flat out
        test_random_traffic(35, 74, PHASE_WORDS);
        test_random_traffic(74, 35, PHASE_WORDS);
        test_random_traffic(0, 0, PHASE_WORDS);

        wait_for_drain();
        $display("run: %0d request words, %0d heap size writes, %0d answers checked",
                 words_accepted, cfg_writes, results_checked);
        $display("run: %0d allocations granted, %0d refused, %0d frees taken, %0d mismatches",
                 allocs_granted, allocs_refused, frees_taken, mismatch_count);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("first_fit_heap_allocator_tb: clean");
        end else begin
            $display("first_fit_heap_allocator_tb: errors");
        end
        $finish;
    end

endmodule
